@@ src/emb_dma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emb_dma_pkg
// Shared types and constants for the emulated memory bus with object DMA.
// ----------------------------------------------------------------------------
package emb_dma_pkg;

    localparam int ADDR_W    = 16;
    localparam int MEM_DEPTH = 65536;
    localparam int DATA_W    = 8;

    localparam int ROM_BYTES = 32768;
    localparam int DMA_BYTES = 160;

    // index of the last byte the copy moves (copy never leaves one page)
    localparam logic [7:0] DMA_LAST = 8'(DMA_BYTES - 1);

    // bus operation codes
    localparam logic [2:0] FUNC_READ    = 3'd0;
    localparam logic [2:0] FUNC_WRITE   = 3'd1;
    localparam logic [2:0] FUNC_ROM     = 3'd2;
    localparam logic [2:0] FUNC_IRQ     = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;
    localparam logic [2:0] FUNC_DIV_RST = 3'd5;

    // address map
    localparam logic [15:0] ADDR_ROM_END   = 16'h7FFF;
    localparam logic [15:0] ADDR_ECHO_LO   = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_HI   = 16'hFDFF;
    localparam logic [15:0] ADDR_UNUSED_LO = 16'hFEA0;
    localparam logic [15:0] ADDR_UNUSED_HI = 16'hFEFF;
    localparam logic [15:0] ADDR_DIV       = 16'hFF04;
    localparam logic [15:0] ADDR_IFLAG     = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA       = 16'hFF46;
    localparam logic [7:0]  OAM_PAGE       = 8'hFE;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [2:0]  irq_bit;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_address;
    } rsp_t;

endpackage
`default_nettype wire

@@ src/emulated_memory_bus_with_dma_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emulated_memory_bus_with_dma_unit
// 64 KiB byte store behind an emulated 8-bit bus with an object DMA copy.
// ----------------------------------------------------------------------------
// Usage:
//   A command (cmd) is taken at a clock edge where start is high and busy is
//   low. Every command produces one result beat on result, marked by done for
//   exactly one cycle; the receiver cannot stall it.
//   Read, write, ROM load and divider reset do not raise busy (a write to
//   0xFF46 apart): the next command may be taken in the following cycle,
//   and the result beat shows in the cycle after the command is taken.
//   Interrupt request and divider tick read, modify and write back the byte
//   store: busy stays high in ST_RMW, and the result beat follows it.
//   A write to 0xFF46 walks DMA_BYTES bytes through the RAM, one byte a
//   cycle with the read of byte k overlapping the write of byte k-1: busy
//   stays high through ST_DMA_RD, ST_DMA_TAIL and ST_DMA_FIN; result follows.
//   This timing is set by the single write port of the byte store RAM.
//   After reset, a clearing pass writes zero to all 65536 bytes, one per
//   cycle; busy stays high for the whole pass.
// ----------------------------------------------------------------------------
module emulated_memory_bus_with_dma_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire emb_dma_pkg::cmd_t  cmd,
    output logic                    done,
    output emb_dma_pkg::rsp_t       result
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_RMW      = 3'd2;
    localparam logic [2:0] ST_DMA_RD   = 3'd3;
    localparam logic [2:0] ST_DMA_TAIL = 3'd4;
    localparam logic [2:0] ST_DMA_FIN  = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [emb_dma_pkg::ADDR_W-1:0]    clr_reg, clr_next;
    logic [7:0]                        idx_reg, idx_next;
    logic                              done_reg, done_next;
    logic                              rd_sel_reg, rd_sel_next;
    logic                              bad_reg, bad_next;
    emb_dma_pkg::cmd_t                 cmd_reg, cmd_next;

    logic                              ram_we;
    logic [emb_dma_pkg::ADDR_W-1:0]    ram_waddr;
    logic [emb_dma_pkg::DATA_W-1:0]    ram_wdata;
    logic [emb_dma_pkg::ADDR_W-1:0]    ram_raddr;
    logic [emb_dma_pkg::DATA_W-1:0]    ram_rdata;

    logic                              accept;

    emb_dma_ram #(
        .WIDTH (emb_dma_pkg::DATA_W),
        .DEPTH (emb_dma_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        rd_sel_next = 1'b0;
        bad_next    = 1'b0;
        cmd_next    = cmd_reg;
        ram_we      = 1'b0;
        ram_waddr   = cmd_reg.addr;
        ram_wdata   = cmd_reg.value;
        ram_raddr   = cmd.addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 16'd1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    done_next = 1'b1;
                    ram_waddr = cmd.addr;
                    ram_wdata = cmd.value;
                    unique case (cmd.func)
                        emb_dma_pkg::FUNC_READ:
                        begin
                            rd_sel_next = 1'b1;
                        end

                        emb_dma_pkg::FUNC_WRITE:
                        begin
                            priority if (cmd.addr <= emb_dma_pkg::ADDR_ROM_END)
                            begin
                                ram_we = 1'b0;
                            end
                            else if (cmd.addr >= emb_dma_pkg::ADDR_ECHO_LO &&
                                     cmd.addr <= emb_dma_pkg::ADDR_ECHO_HI)
                            begin
                                bad_next = 1'b1;
                            end
                            else if (cmd.addr >= emb_dma_pkg::ADDR_UNUSED_LO &&
                                     cmd.addr <= emb_dma_pkg::ADDR_UNUSED_HI)
                            begin
                                ram_we = 1'b0;
                            end
                            else if (cmd.addr == emb_dma_pkg::ADDR_DIV)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = '0;
                            end
                            else if (cmd.addr == emb_dma_pkg::ADDR_DMA)
                            begin
                                done_next  = 1'b0;
                                idx_next   = '0;
                                state_next = ST_DMA_RD;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end

                        emb_dma_pkg::FUNC_ROM:
                        begin
                            ram_we = ({1'b0, cmd.addr} < 17'(emb_dma_pkg::ROM_BYTES));
                        end

                        emb_dma_pkg::FUNC_IRQ:
                        begin
                            done_next  = 1'b0;
                            ram_raddr  = emb_dma_pkg::ADDR_IFLAG;
                            state_next = ST_RMW;
                        end

                        emb_dma_pkg::FUNC_TICK:
                        begin
                            done_next  = 1'b0;
                            ram_raddr  = emb_dma_pkg::ADDR_DIV;
                            state_next = ST_RMW;
                        end

                        emb_dma_pkg::FUNC_DIV_RST:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = emb_dma_pkg::ADDR_DIV;
                            ram_wdata = '0;
                        end

                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end

            ST_RMW:
            begin
                ram_we     = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (cmd_reg.func == emb_dma_pkg::FUNC_IRQ)
                begin
                    ram_waddr = emb_dma_pkg::ADDR_IFLAG;
                    ram_wdata = ram_rdata | (8'd1 << cmd_reg.irq_bit);
                end
                else
                begin
                    ram_waddr = emb_dma_pkg::ADDR_DIV;
                    ram_wdata = ram_rdata + 8'd1;
                end
            end

            ST_DMA_RD:
            begin
                // read byte k while writing byte k-1 fetched last cycle
                ram_raddr = {cmd_reg.value, idx_reg};
                ram_we    = (idx_reg != '0);
                ram_waddr = {emb_dma_pkg::OAM_PAGE, 8'(idx_reg - 8'd1)};
                ram_wdata = ram_rdata;
                if (idx_reg == emb_dma_pkg::DMA_LAST)
                begin
                    state_next = ST_DMA_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 8'd1;
                end
            end

            ST_DMA_TAIL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {emb_dma_pkg::OAM_PAGE, emb_dma_pkg::DMA_LAST};
                ram_wdata  = ram_rdata;
                state_next = ST_DMA_FIN;
            end

            ST_DMA_FIN:
            begin
                // register itself is stored only after the copy
                ram_we     = 1'b1;
                ram_waddr  = emb_dma_pkg::ADDR_DMA;
                ram_wdata  = cmd_reg.value;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rd_sel_reg <= rd_sel_next;
        bad_reg    <= bad_next;
    end

    assign done               = done_reg;
    assign result.read_data   = rd_sel_reg ? ram_rdata : '0;
    assign result.bad_address = bad_reg;

endmodule
`default_nettype wire

@@ src/emb_dma_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emb_dma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module emb_dma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the emulated memory bus with object DMA. A directed
// table covers the address map edges, every bus operation and the DMA overlap
// cases; a long random run of bus sequences follows. Every result beat is
// compared with the table's expected value or with a shadow copy of the 64 KiB byte store kept in the bench.
// ----------------------------------------------------------------------------
module tb;

    import emb_dma_pkg::*;

    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    localparam int RAND_ITEMS   = 800;
    localparam int IDLE_PCT     = 16;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam rsp_t RSP_NONE = '0;

    typedef struct {
        cmd_t op;
        bit   fixed;
        rsp_t rsp;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t result;

    // shadow of the byte store and the beats still owed by the block
    logic [7:0] bus_bytes [0:MEM_DEPTH-1];
    rsp_t       pending_bus_rsp [$];
    rsp_t       oldest_rsp;
    dir_row_t   dir_rows [$];

    int n_fail   = 0;
    int n_issued = 0;
    int n_cycles = 0;

    emulated_memory_bus_with_dma_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result beats: receiver never stalls, so check every done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_bus_rsp.size() == 0)
            begin
                $error("result beat with no command outstanding");
                n_fail++;
            end
            else
            begin
                oldest_rsp = pending_bus_rsp.pop_front();
                if (result.read_data !== oldest_rsp.read_data)
                begin
                    $error("read_data: expected %02h, got %02h",
                           oldest_rsp.read_data, result.read_data);
                    n_fail++;
                end
                if (result.bad_address !== oldest_rsp.bad_address)
                begin
                    $error("bad_address: expected %0b, got %0b",
                           oldest_rsp.bad_address, result.bad_address);
                    n_fail++;
                end
            end
        end
    end

    function automatic rsp_t bus_op_result(input cmd_t c);
        rsp_t        r;
        logic [15:0] src_a;
        logic [15:0] dst_a;
        int          k;
        r = '0;
        case (c.func)
            FUNC_READ:
                r.read_data = bus_bytes[c.addr];
            FUNC_WRITE:
            begin
                if (c.addr > ADDR_ROM_END)
                begin
                    if (c.addr >= ADDR_ECHO_LO && c.addr <= ADDR_ECHO_HI)
                        r.bad_address = 1'b1;
                    else if (!(c.addr >= ADDR_UNUSED_LO && c.addr <= ADDR_UNUSED_HI))
                    begin
                        if (c.addr == ADDR_DIV)
                            bus_bytes[ADDR_DIV] = 8'h00;
                        else if (c.addr == ADDR_DMA)
                        begin
                            // copy sees the old dma register, rising order
                            for (k = 0; k < DMA_BYTES; k++)
                            begin
                                src_a = {c.value, 8'h00} + 16'(k);
                                dst_a = {OAM_PAGE, 8'h00} + 16'(k);
                                bus_bytes[dst_a] = bus_bytes[src_a];
                            end
                            bus_bytes[ADDR_DMA] = c.value;
                        end
                        else
                            bus_bytes[c.addr] = c.value;
                    end
                end
            end
            FUNC_ROM:
            begin
                if (int'(c.addr) < ROM_BYTES)
                    bus_bytes[c.addr] = c.value;
            end
            FUNC_IRQ:
                bus_bytes[ADDR_IFLAG] = bus_bytes[ADDR_IFLAG] | (8'h01 << c.irq_bit);
            FUNC_TICK:
                bus_bytes[ADDR_DIV] = bus_bytes[ADDR_DIV] + 8'h01;
            FUNC_DIV_RST:
                bus_bytes[ADDR_DIV] = 8'h00;
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input logic [2:0] f, input logic [15:0] a,
                                    input logic [7:0] v, input logic [2:0] b);
        cmd_t c;
        c.func    = f;
        c.addr    = a;
        c.value   = v;
        c.irq_bit = b;
        return c;
    endfunction

    function automatic dir_row_t mk_row(input cmd_t c, input bit fixed,
                                        input logic [7:0] rd, input logic bad);
        dir_row_t row;
        row.op              = c;
        row.fixed           = fixed;
        row.rsp.read_data   = rd;
        row.rsp.bad_address = bad;
        return row;
    endfunction

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(16'h0000, 16'h7FFF));
            1: return 16'($urandom_range(16'hE000, 16'hFDFF));
            2: return 16'($urandom_range(16'hFE00, 16'hFEFF));
            3: return 16'($urandom_range(16'hFF00, 16'hFFFF));
            4:
            begin
                case ($urandom_range(0, 9))
                    0: return ADDR_DIV;
                    1: return ADDR_IFLAG;
                    2: return ADDR_DMA;
                    3: return ADDR_ROM_END;
                    4: return ADDR_ROM_END + 16'd1;
                    5: return ADDR_ECHO_LO - 16'd1;
                    6: return ADDR_ECHO_HI + 16'd1;
                    7: return ADDR_UNUSED_LO - 16'd1;
                    8: return ADDR_UNUSED_HI + 16'd1;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    // one command beat; returns at the edge that takes it, or after a random idle spell with start low
    task automatic issue_op(input cmd_t c, input bit fixed, input rsp_t fixed_rsp);
        rsp_t r;
        bit   quiet;
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = bus_op_result(c);
        pending_bus_rsp.push_back(fixed ? fixed_rsp : r);
        n_issued++;
        quiet = (n_issued >= 300 && n_issued < 450);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic issue(input cmd_t c);
        issue_op(c, 1'b0, RSP_NONE);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_bus_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] page;
        int         n_dir;
        bit         long_run_done;

        foreach (bus_bytes[i])
            bus_bytes[i] = 8'h00;

        // directed table: map edges, every op, dma overlap
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'h0000, 8'h00, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'hFFFF, 8'hFF, 3'd7), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_ROM,     16'h0000, 8'hFF, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_ROM,     16'h7FFF, 8'hA5, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_ROM,     16'h8000, 8'h5A, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'h0000, 8'h00, 3'd0), 1, 8'hFF, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'h7FFF, 8'h00, 3'd0), 1, 8'hA5, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'h8000, 8'h00, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'h0000, 8'h12, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'hE000, 8'h33, 3'd0), 1, 8'h00, 1));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'hFDFF, 8'h44, 3'd0), 1, 8'h00, 1));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'hFEA0, 8'h55, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'hC000, 8'h77, 3'd0), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   16'hC09F, 8'h66, 3'd0), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   ADDR_DMA, 8'hC0, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'hFE00, 8'h00, 3'd0), 1, 8'h77, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'hFE9F, 8'h00, 3'd0), 1, 8'h66, 0));
        // source page overlaps the dma register itself
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   ADDR_DMA, 8'hFF, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    16'hFE46, 8'h00, 3'd0), 1, 8'hC0, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_TICK,    16'h0000, 8'h00, 3'd0), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    ADDR_DIV, 8'h00, 3'd0), 1, 8'h01, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_DIV_RST, 16'h0000, 8'h00, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_TICK,    16'h0000, 8'h00, 3'd0), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_WRITE,   ADDR_DIV, 8'hAA, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    ADDR_DIV, 8'h00, 3'd0), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_IRQ,     16'h0000, 8'h00, 3'd7), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_IRQ,     16'h0000, 8'h00, 3'd0), 0, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_READ,    ADDR_IFLAG, 8'h00, 3'd0), 1, 8'h81, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_SPARE6,  16'hFFFF, 8'hFF, 3'd7), 1, 8'h00, 0));
        dir_rows.push_back(mk_row(mk_cmd(FUNC_SPARE7,  ADDR_DMA, 8'hFF, 3'd7), 1, 8'h00, 0));

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].rsp);
        n_dir = n_issued;
        long_run_done = 0;

        while (n_issued < n_dir + RAND_ITEMS)
        begin
            if (!long_run_done && n_issued >= n_dir + RAND_ITEMS / 2)
            begin
                // drain, then walk the divider all the way round
                hold_until_drained();
                issue(mk_cmd(FUNC_DIV_RST, 16'($urandom()), 8'($urandom()), 3'($urandom())));
                repeat (256 + $urandom_range(0, 6))
                    issue(mk_cmd(FUNC_TICK, 16'($urandom()), 8'($urandom()),
                                 3'($urandom())));
                issue(mk_cmd(FUNC_READ, ADDR_DIV, 8'($urandom()), 3'($urandom())));
                long_run_done = 1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    issue(mk_cmd(3'($urandom_range(0, 7)), pick_addr(), 8'($urandom()),
                                 3'($urandom())));
                4, 5:
                begin
                    // seed a source page, trigger the copy, read object bytes back
                    page = 8'($urandom());
                    repeat ($urandom_range(1, 4))
                        issue(mk_cmd(page < 8'h80 ? FUNC_ROM : FUNC_WRITE,
                                     {page, 8'($urandom_range(0, DMA_BYTES - 1))},
                                     8'($urandom()), 3'($urandom())));
                    issue(mk_cmd(FUNC_WRITE, ADDR_DMA, page, 3'($urandom())));
                    repeat ($urandom_range(2, 5))
                        issue(mk_cmd(FUNC_READ,
                                     {OAM_PAGE, 8'($urandom_range(0, 255))},
                                     8'($urandom()), 3'($urandom())));
                    issue(mk_cmd(FUNC_READ, {OAM_PAGE, DMA_LAST}, 8'($urandom()),
                                 3'($urandom())));
                end
                6:
                begin
                    if ($urandom_range(0, 2) == 0)
                        issue(mk_cmd(FUNC_WRITE, ADDR_IFLAG, 8'($urandom()),
                                     3'($urandom())));
                    repeat ($urandom_range(1, 4))
                        issue(mk_cmd(FUNC_IRQ, 16'($urandom()), 8'($urandom()),
                                     3'($urandom())));
                    issue(mk_cmd(FUNC_READ, ADDR_IFLAG, 8'($urandom()), 3'($urandom())));
                end
                7:
                begin
                    if ($urandom_range(0, 1) == 0)
                        issue(mk_cmd(FUNC_DIV_RST, 16'($urandom()), 8'($urandom()),
                                     3'($urandom())));
                    else if ($urandom_range(0, 1) == 0)
                        issue(mk_cmd(FUNC_WRITE, ADDR_DIV, 8'($urandom()),
                                     3'($urandom())));
                    repeat ($urandom_range(1, 12))
                        issue(mk_cmd(FUNC_TICK, 16'($urandom()), 8'($urandom()),
                                     3'($urandom())));
                    issue(mk_cmd(FUNC_READ, ADDR_DIV, 8'($urandom()), 3'($urandom())));
                end
                8:
                begin
                    cmd_t ld;
                    ld = mk_cmd(FUNC_ROM, 16'($urandom()), 8'($urandom()), 3'($urandom()));
                    issue(ld);
                    issue(mk_cmd(FUNC_READ, ld.addr, 8'($urandom()), 3'($urandom())));
                end
                default:
                begin
                    cmd_t wr;
                    wr = mk_cmd(FUNC_WRITE, pick_addr(), 8'($urandom()), 3'($urandom()));
                    issue(wr);
                    issue(mk_cmd(FUNC_READ, wr.addr, 8'($urandom()), 3'($urandom())));
                end
            endcase
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (n_fail == 0 && pending_bus_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
